/* design/min_tracking_stack_macros.svh */
// Assertion macros used by the min tracking stack datapath (mts_dp).
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define MTS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("min tracking stack: same-cycle check failed");

// Check that cons holds in the cycle after ante holds.
`define MTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("min tracking stack: next-cycle check failed");

`endif

/* design/mts_pkg.sv */
// Shared types and codes of the min tracking stack.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

	// Operation codes carried in s_tuser; the unused code acts as a peek.
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} stat_code_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_RESP
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic       push_en;    // write new entry, update top and min
		logic       pop_en;     // drop top entry
		logic       rd_en;      // read the entry now on top
		logic       load_en;    // move read data into top and min
		logic       status_wr;  // capture status
		stat_code_t status;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic one;
	} dp_stat_t;

endpackage

`default_nettype wire

/* design/min_tracking_stack.sv */
// Top level of the min tracking stack: stream ports, controller and datapath.
//
// Channel  | Dir | Handshake          | Content
// s_*      | in  | s_tvalid/s_tready  | tdata: push_value; tuser: opcode
// m_*      | out | m_tvalid/m_tready  | tdata: top_value, min_value; tuser: is_empty, status
//
// Push, peek, pop of the last entry, refused push and refused pop present the result
// in the cycle after accept; a pop that leaves entries presents it only after the
// read and load states, set by the registered read port of the entry memory
// (read, then load into the top and minimum registers).
// One item is in flight at a time; s_tready stays low until the result is taken.
// A stalled m_tready holds the result and all state.
// Reset empties the stack at once; the entry memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack #(
	parameter int STACK_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] push_value
	input  wire logic [1:0]  s_tuser,   // [1:0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [31:0] top_value, [63:32] min_value
	output logic [2:0]       m_tuser    // [0] is_empty, [2:1] status
);

	mts_pkg::dp_cmd_t  cmd;
	mts_pkg::dp_stat_t stat;

	logic signed [31:0] top_value;
	logic signed [31:0] min_value;
	logic               is_empty;
	logic [1:0]         status;

	// Controller: sequence each item, drive memory commands, hold the result.
	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.opcode    (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: entries and running minimums in memory, top copy in registers.
	mts_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value ($signed(s_tdata)),
		.stat       (stat),
		.top_value  (top_value),
		.min_value  (min_value),
		.is_empty   (is_empty),
		.status     (status)
	);

	// Pack the result item.
	assign m_tdata = {min_value, top_value};
	assign m_tuser = {status, is_empty};

endmodule

`default_nettype wire

/* design/mts_ctrl.sv */
// Controller state machine of the min tracking stack.
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        opcode,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire mts_pkg::dp_stat_t stat,
	output mts_pkg::dp_cmd_t       cmd
);

	mts_pkg::state_t state_q;
	mts_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mts_pkg::S_IDLE: begin
				if (in_valid) begin
					// Pop that leaves entries behind must fetch the new top.
					if (opcode == mts_pkg::OP_POP && !stat.empty && !stat.one) begin
						state_d = mts_pkg::S_READ;
					end else begin
						state_d = mts_pkg::S_RESP;
					end
				end
			end
			mts_pkg::S_READ: begin
				state_d = mts_pkg::S_LOAD;
			end
			mts_pkg::S_LOAD: begin
				state_d = mts_pkg::S_RESP;
			end
			mts_pkg::S_RESP: begin
				if (out_ready) begin
					state_d = mts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mts_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		cmd.status = mts_pkg::ST_OK;
		unique case (state_q)
			mts_pkg::S_IDLE: begin
				in_ready      = 1'b1;
				cmd.status_wr = in_valid;
				unique case (opcode)
					mts_pkg::OP_PUSH: begin
						if (stat.full) begin
							cmd.status = mts_pkg::ST_FULL;
						end else begin
							cmd.push_en = in_valid;
						end
					end
					mts_pkg::OP_POP: begin
						if (stat.empty) begin
							cmd.status = mts_pkg::ST_EMPTY;
						end else begin
							cmd.pop_en = in_valid;
						end
					end
					default: begin
						cmd.status = mts_pkg::ST_OK;
					end
				endcase
			end
			mts_pkg::S_READ: begin
				cmd.rd_en = 1'b1;
			end
			mts_pkg::S_LOAD: begin
				cmd.load_en = 1'b1;
			end
			mts_pkg::S_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/mts_dp.sv */
// Datapath of the min tracking stack: entry memory, top and minimum registers, count.
`timescale 1ns / 1ps
`default_nettype none
`include "min_tracking_stack_macros.svh"

module mts_dp #(
	parameter int STACK_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mts_pkg::dp_cmd_t   cmd,
	input  wire logic signed [31:0] push_value,
	output mts_pkg::dp_stat_t       stat,
	output logic signed [31:0]      top_value,
	output logic signed [31:0]      min_value,
	output logic                    is_empty,
	output logic [1:0]              status
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// Each memory word holds {running minimum, value}.
	logic [63:0] mem [STACK_DEPTH];

	logic [CW-1:0]       count_q;
	logic signed [31:0]  top_q;
	logic signed [31:0]  min_q;
	logic [63:0]         rd_data_q;
	mts_pkg::stat_code_t status_q;

	logic [CW-1:0]      top_idx;
	logic signed [31:0] new_min;

	assign top_idx = count_q - CW'(1);

	// Running minimum: the pushed value alone on an empty stack.
	assign new_min = (count_q == '0 || push_value < min_q) ? push_value : min_q;

	assign stat.full  = (count_q == CW'(STACK_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.one   = (count_q == CW'(1));

	always_ff @(posedge clk) begin
		if (cmd.push_en) begin
			mem[count_q[AW-1:0]] <= {new_min, push_value};
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[top_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= mts_pkg::ST_OK;
		end else begin
			if (cmd.push_en) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_en) begin
				count_q <= top_idx;
			end
			if (cmd.status_wr) begin
				status_q <= cmd.status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_en) begin
			top_q <= push_value;
			min_q <= new_min;
		end else if (cmd.load_en) begin
			top_q <= rd_data_q[31:0];
			min_q <= rd_data_q[63:32];
		end
	end

	assign is_empty  = stat.empty;
	assign top_value = stat.empty ? '0 : top_q;
	assign min_value = stat.empty ? '0 : min_q;
	assign status    = status_q;

	`MTS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(STACK_DEPTH))
	`MTS_ASSERT_NEXT(a_push_min_le_top, cmd.push_en, min_q <= top_q)
	`MTS_ASSERT_NEXT(a_read_min_le_val, cmd.rd_en, $signed(rd_data_q[63:32]) <= $signed(rd_data_q[31:0]))

endmodule

`default_nettype wire
